/* rtl/bgc_pkg.sv */
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, codes and reset values of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CodeW  = 4;

  localparam logic [LimitW-1:0] LongPressResetMs = 16'd800;
  localparam logic [LimitW-1:0] DoubleGapResetMs = 16'd600;

  // configuration register indexes
  localparam logic RegLongPressMs = 1'b0;
  localparam logic RegDoubleGapMs = 1'b1;

  // item kinds on the input channel
  localparam logic FuncSample = 1'b0;
  localparam logic FuncTick   = 1'b1;

  typedef enum logic [1:0] {
    KIND_SHORT  = 2'd0,
    KIND_LONG   = 2'd1,
    KIND_DOUBLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SIDE_LEFT  = 2'd0,
    SIDE_RIGHT = 2'd1,
    SIDE_BOTH  = 2'd2
  } side_e;

  typedef struct packed {
    logic [LimitW-1:0] long_press_ms;
    logic [LimitW-1:0] gap_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic             left_pressed;
    logic             right_pressed;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] gesture_code;
    side_e            gesture_side;
    kind_e            gesture_kind;
  } result_t;

  function automatic side_e side_of(input logic both, input logic left);
    side_e s;
    if (both) begin
      s = SIDE_BOTH;
    end else if (left) begin
      s = SIDE_LEFT;
    end else begin
      s = SIDE_RIGHT;
    end
    return s;
  endfunction

  // kind + 1 + 3 * side
  function automatic logic [CodeW-1:0] code_of(input side_e side, input kind_e kind);
    logic [CodeW-1:0] s;
    s = {2'b00, side};
    return (s << 1) + s + {2'b00, kind} + 4'd1;
  endfunction

  function automatic result_t make_result(input side_e side, input kind_e kind);
    result_t r;
    r.gesture_code = code_of(side, kind);
    r.gesture_side = side;
    r.gesture_kind = kind;
    return r;
  endfunction

endpackage

/* rtl/bgc_item_if.sv */
// ----------------------------------------------------------------------------
// bgc_item_if
// Input channel: a button sample or a timer tick with its timestamp.
// ----------------------------------------------------------------------------
interface bgc_item_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic                      left_pressed;
  logic                      right_pressed;
  logic [bgc_pkg::TimeW-1:0] now_ms;

  modport source (output valid, func, left_pressed, right_pressed, now_ms, input ready);
  modport sink   (input valid, func, left_pressed, right_pressed, now_ms, output ready);
endinterface

/* rtl/bgc_result_if.sv */
// ----------------------------------------------------------------------------
// bgc_result_if
// Output channel: one classified gesture.
// ----------------------------------------------------------------------------
interface bgc_result_if;
  logic                      valid;
  logic                      ready;
  logic [bgc_pkg::CodeW-1:0] gesture_code;
  logic [1:0]                gesture_side;
  logic [1:0]                gesture_kind;

  modport source (output valid, gesture_code, gesture_side, gesture_kind, input ready);
  modport sink   (input valid, gesture_code, gesture_side, gesture_kind, output ready);
endinterface

/* rtl/bgc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Long press and double gap limit registers behind a plain write port.
// ----------------------------------------------------------------------------
module bgc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bgc_pkg::LimitW-1:0] cfg_wdata_i,
  output bgc_pkg::cfg_t              cfg_o
);

  bgc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bgc_pkg::RegLongPressMs: cfg_d.long_press_ms = cfg_wdata_i;
        bgc_pkg::RegDoubleGapMs: cfg_d.gap_limit_ms = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms <= bgc_pkg::LongPressResetMs;
      cfg_q.gap_limit_ms  <= bgc_pkg::DoubleGapResetMs;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/bgc_core.sv */
// ----------------------------------------------------------------------------
// bgc_core
// Press tracking state and the gesture decision for one staged item.
// ----------------------------------------------------------------------------
module bgc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bgc_pkg::cfg_t    cfg_i,
  input  bgc_pkg::item_t   item_i,
  input  logic             adv_i,
  output logic             has_res_o,
  output bgc_pkg::result_t res_o
);

  logic held_d, held_q;
  logic both_seen_d, both_seen_q;
  logic press_left_d, press_left_q;
  logic [bgc_pkg::TimeW-1:0] press_start_d, press_start_q;
  logic consumed_d, consumed_q;
  logic pending_d, pending_q;
  logic pend_left_d, pend_left_q;
  logic pend_both_d, pend_both_q;
  logic [bgc_pkg::TimeW-1:0] release_d, release_q;

  logic any_btn, both_btn, gap_ok, long_ok, match;
  logic [bgc_pkg::TimeW-1:0] since_rel, held_for;
  bgc_pkg::side_e pend_side;

  assign any_btn   = item_i.left_pressed | item_i.right_pressed;
  assign both_btn  = item_i.left_pressed & item_i.right_pressed;
  assign since_rel = item_i.now_ms - release_q;
  assign held_for  = item_i.now_ms - press_start_q;
  assign gap_ok    = since_rel <= {16'd0, cfg_i.gap_limit_ms};
  assign long_ok   = held_for >= {16'd0, cfg_i.long_press_ms};
  assign match     = gap_ok && (pend_both_q == both_btn) && (pend_left_q == item_i.left_pressed);
  assign pend_side = bgc_pkg::side_of(pend_both_q, pend_left_q);

  always_comb begin
    held_d        = held_q;
    both_seen_d   = both_seen_q;
    press_left_d  = press_left_q;
    press_start_d = press_start_q;
    consumed_d    = consumed_q;
    pending_d     = pending_q;
    pend_left_d   = pend_left_q;
    pend_both_d   = pend_both_q;
    release_d     = release_q;
    has_res_o     = 1'b0;
    res_o         = bgc_pkg::make_result(bgc_pkg::SIDE_LEFT, bgc_pkg::KIND_SHORT);

    if (item_i.func == bgc_pkg::FuncTick) begin
      // tick only expires a pending short press
      if (pending_q && !gap_ok) begin
        pending_d = 1'b0;
        has_res_o = 1'b1;
        res_o     = bgc_pkg::make_result(pend_side, bgc_pkg::KIND_SHORT);
      end
    end else if (any_btn && !held_q) begin
      held_d        = 1'b1;
      press_start_d = item_i.now_ms;
      both_seen_d   = both_btn;
      press_left_d  = item_i.left_pressed;
      consumed_d    = 1'b0;
      if (pending_q) begin
        pending_d = 1'b0;
        has_res_o = 1'b1;
        if (match) begin
          // second press of a double: its release is swallowed
          consumed_d = 1'b1;
          res_o      = bgc_pkg::make_result(pend_side, bgc_pkg::KIND_DOUBLE);
        end else begin
          res_o = bgc_pkg::make_result(pend_side, bgc_pkg::KIND_SHORT);
        end
      end
    end else if (any_btn && held_q) begin
      if (both_btn) begin
        both_seen_d = 1'b1;
      end
    end else if (held_q) begin
      held_d = 1'b0;
      if (!consumed_q) begin
        if (long_ok) begin
          has_res_o = 1'b1;
          res_o     = bgc_pkg::make_result(bgc_pkg::side_of(both_seen_q, press_left_q),
                                           bgc_pkg::KIND_LONG);
        end else begin
          pending_d   = 1'b1;
          pend_left_d = press_left_q;
          pend_both_d = both_seen_q;
          release_d   = item_i.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= 1'b0;
      both_seen_q   <= 1'b0;
      press_left_q  <= 1'b0;
      press_start_q <= '0;
      consumed_q    <= 1'b0;
      pending_q     <= 1'b0;
      pend_left_q   <= 1'b0;
      pend_both_q   <= 1'b0;
      release_q     <= '0;
    end else if (adv_i) begin
      held_q        <= held_d;
      both_seen_q   <= both_seen_d;
      press_left_q  <= press_left_d;
      press_start_q <= press_start_d;
      consumed_q    <= consumed_d;
      pending_q     <= pending_d;
      pend_left_q   <= pend_left_d;
      pend_both_q   <= pend_both_d;
      release_q     <= release_d;
    end
  end

endmodule

/* rtl/button_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Short, long and double press detection for a two-button pad.
// ----------------------------------------------------------------------------
// Takes one request per clock: button samples and timer ticks are captured in
// an input register, classified in a single pass against the press state and
// the gesture, if any, lands in a result register, from which it is offered
// on the result channel. The input side only holds off while a gesture waits
// in the result register and the staged request would produce another one.
// Limits are written through cfg_we_i, index 0 long press, index 1 double
// gap, in milliseconds.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bgc_pkg::LimitW-1:0] cfg_wdata_i,
  bgc_item_if.sink                   item_i,
  bgc_result_if.source               result_o
);

  bgc_pkg::cfg_t    cfg;
  bgc_pkg::item_t   stg_d, stg_q;
  logic             stg_valid_q;
  logic             has_res, adv, out_free;
  bgc_pkg::result_t res, out_q;
  logic             out_valid_q;

  bgc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  bgc_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg),
    .item_i    (stg_q),
    .adv_i     (adv),
    .has_res_o (has_res),
    .res_o     (res)
  );

  assign out_free     = !out_valid_q || result_o.ready;
  assign adv          = stg_valid_q && (!has_res || out_free);
  assign item_i.ready = !stg_valid_q || adv;

  assign stg_d.func          = item_i.func;
  assign stg_d.left_pressed  = item_i.left_pressed;
  assign stg_d.right_pressed = item_i.right_pressed;
  assign stg_d.now_ms        = item_i.now_ms;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      stg_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      stg_q <= stg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && has_res) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.gesture_code = out_q.gesture_code;
  assign result_o.gesture_side = out_q.gesture_side;
  assign result_o.gesture_kind = out_q.gesture_kind;

endmodule

/* test/button_gesture_classifier_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_checker
// Watches the request and gesture channels and the limit writes. It keeps its
// own copy of the press tracking state, works out the gesture that each
// accepted request should cause, and compares every gesture that leaves the
// block, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module button_gesture_classifier_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bgc_pkg::LimitW-1:0] cfg_wdata_i,
  bgc_item_if                        item_i,
  bgc_result_if                      result_i,
  output logic                       gestures_due_o,
  output int unsigned                mismatch_cnt_o
);
  import bgc_pkg::*;

  typedef struct packed {
    logic             held;
    logic             both_seen;
    logic             first_left;
    logic [TimeW-1:0] start_ms;
    logic             consumed;
    logic             pending;
    logic             pend_left;
    logic             pend_both;
    logic [TimeW-1:0] release_ms;
  } press_track_t;

  press_track_t pad;
  cfg_t         limits;
  result_t      gesture_q [$];
  result_t      predicted;
  result_t      oldest;
  int unsigned  mismatches;

  assign mismatch_cnt_o = mismatches;

  function automatic side_e side_for(input logic both, input logic left);
    side_e s;
    if (both) begin
      s = SIDE_BOTH;
    end else if (left) begin
      s = SIDE_LEFT;
    end else begin
      s = SIDE_RIGHT;
    end
    return s;
  endfunction

  function automatic result_t gesture_of(input side_e side, input kind_e kind);
    result_t r;
    r.gesture_code = CodeW'(32'(kind) + 32'd1 + 32'd3 * 32'(side));
    r.gesture_side = side;
    r.gesture_kind = kind;
    return r;
  endfunction

  // updates the press tracking and returns 1 when the request causes a gesture
  function automatic logic predict_gesture(input item_t it, output result_t g);
    logic             hit;
    logic             any_btn;
    logic             both_btn;
    logic             is_double;
    logic [TimeW-1:0] since_release;
    hit           = 1'b0;
    g             = '0;
    any_btn       = it.left_pressed | it.right_pressed;
    both_btn      = it.left_pressed & it.right_pressed;
    since_release = it.now_ms - pad.release_ms;
    if (it.func == FuncTick) begin
      // a tick only closes out a pending short press
      if (pad.pending && since_release > TimeW'(limits.gap_limit_ms)) begin
        pad.pending = 1'b0;
        g   = gesture_of(side_for(pad.pend_both, pad.pend_left), KIND_SHORT);
        hit = 1'b1;
      end
    end else if (any_btn && !pad.held) begin
      pad.held       = 1'b1;
      pad.start_ms   = it.now_ms;
      pad.both_seen  = both_btn;
      pad.first_left = it.left_pressed;
      pad.consumed   = 1'b0;
      if (pad.pending) begin
        is_double = since_release <= TimeW'(limits.gap_limit_ms) &&
                    pad.pend_both == both_btn && pad.pend_left == it.left_pressed;
        pad.pending  = 1'b0;
        pad.consumed = is_double;
        g   = gesture_of(side_for(pad.pend_both, pad.pend_left),
                         is_double ? KIND_DOUBLE : KIND_SHORT);
        hit = 1'b1;
      end
    end else if (any_btn) begin
      if (both_btn) begin
        pad.both_seen = 1'b1;
      end
    end else if (pad.held) begin
      pad.held = 1'b0;
      // the second press of a double ends silently
      if (!pad.consumed) begin
        if (it.now_ms - pad.start_ms >= TimeW'(limits.long_press_ms)) begin
          g   = gesture_of(side_for(pad.both_seen, pad.first_left), KIND_LONG);
          hit = 1'b1;
        end else begin
          pad.pending    = 1'b1;
          pad.pend_left  = pad.first_left;
          pad.pend_both  = pad.both_seen;
          pad.release_ms = it.now_ms;
        end
      end
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad                  = '0;
      limits.long_press_ms = LongPressResetMs;
      limits.gap_limit_ms  = DoubleGapResetMs;
      gesture_q.delete();
      mismatches           = 0;
      gestures_due_o       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLongPressMs: limits.long_press_ms = cfg_wdata_i;
          RegDoubleGapMs: limits.gap_limit_ms = cfg_wdata_i;
          default: ;
        endcase
      end
      // gestures first, so a stray one is never matched by this cycle's request
      if (result_i.valid && result_i.ready) begin
        if (gesture_q.size() == 0) begin
          report_mismatch("gesture with none due, code", 32'(result_i.gesture_code), 0);
        end else begin
          oldest = gesture_q.pop_front();
          if (result_i.gesture_code !== oldest.gesture_code) begin
            report_mismatch("gesture_code", 32'(result_i.gesture_code),
                            32'(oldest.gesture_code));
          end
          if (result_i.gesture_side !== oldest.gesture_side) begin
            report_mismatch("gesture_side", 32'(result_i.gesture_side),
                            32'(oldest.gesture_side));
          end
          if (result_i.gesture_kind !== oldest.gesture_kind) begin
            report_mismatch("gesture_kind", 32'(result_i.gesture_kind),
                            32'(oldest.gesture_kind));
          end
        end
      end
      if (item_i.valid && item_i.ready) begin
        if (predict_gesture({item_i.func, item_i.left_pressed, item_i.right_pressed,
                             item_i.now_ms}, predicted)) begin
          gesture_q.push_back(predicted);
        end
      end
      gestures_due_o <= (gesture_q.size() != 0);
    end
  end

endmodule

/* test/button_gesture_classifier_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_test
// Drives button samples and timer ticks into the classifier: a directed
// opening at the reset limits, then random press sequences under several
// limit settings, with random request gaps and gesture stalls except in the
// last two phases. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module button_gesture_classifier_test;
  import bgc_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 150;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic              cfg_idx;
  logic [LimitW-1:0] cfg_wdata;
  logic              gestures_due;
  int unsigned       mismatch_cnt;

  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       items_sent;
  int unsigned       quiet_cycles;
  int unsigned       last_side;
  logic [TimeW-1:0]  stamp_ms;
  logic [LimitW-1:0] long_ms;
  logic [LimitW-1:0] gap_ms;
  item_t             opening_seq [25];

  bgc_item_if   item_if ();
  bgc_result_if result_if ();

  button_gesture_classifier u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  button_gesture_classifier_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .item_i        (item_if),
    .result_i      (result_if),
    .gestures_due_o(gestures_due),
    .mismatch_cnt_o(mismatch_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic func, input logic l_btn, input logic r_btn,
                           input logic [TimeW-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.func          <= func;
    item_if.left_pressed  <= l_btn;
    item_if.right_pressed <= r_btn;
    item_if.now_ms        <= stamp;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
  endtask

  // lowers valid and waits until every due gesture is out and the pipe is empty
  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (gestures_due) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [LimitW-1:0] long_val,
                              input logic [LimitW-1:0] gap_val);
    cfg_we    <= 1'b1;
    cfg_idx   <= RegLongPressMs;
    cfg_wdata <= long_val;
    @(posedge clk_i);
    cfg_idx   <= RegDoubleGapMs;
    cfg_wdata <= gap_val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    long_ms = long_val;
    gap_ms  = gap_val;
  endtask

  // a span around a limit: zero, at it, one off either way, up to it or far off
  function automatic logic [TimeW-1:0] pick_span(input logic [LimitW-1:0] limit);
    logic [TimeW-1:0] wide;
    logic [TimeW-1:0] span;
    wide = TimeW'(limit);
    case ($urandom_range(5))
      0:       span = '0;
      1:       span = wide;
      2:       span = wide + 1;
      3:       span = wide - 1;
      4:       span = $urandom_range(wide);
      default: span = $urandom_range(100000);
    endcase
    return span;
  endfunction

  // one press with random side, hold and gap, sometimes preceded by a tick
  task automatic play_gesture();
    logic [TimeW-1:0] press_at;
    logic [TimeW-1:0] hold;
    logic             l0;
    logic             r0;
    logic [1:0]       btns;
    int unsigned      n_hold;
    press_at = stamp_ms + pick_span(gap_ms);
    if ($urandom_range(9) < 3) begin
      send_item(FuncTick, 1'($urandom_range(1)), 1'($urandom_range(1)),
                stamp_ms + pick_span(gap_ms));
    end
    // repeating the side makes doubles likely
    if ($urandom_range(1) == 0) begin
      last_side = $urandom_range(4);
    end
    case (last_side)
      0, 3:    {l0, r0} = 2'b10;
      1, 4:    {l0, r0} = 2'b01;
      default: {l0, r0} = 2'b11;
    endcase
    send_item(FuncSample, l0, r0, press_at);
    hold   = pick_span(long_ms);
    n_hold = $urandom_range(2, (last_side >= 3) ? 1 : 0);
    repeat (n_hold) begin
      if (last_side >= 3) begin
        btns = 2'b11;
      end else if ($urandom_range(4) == 0) begin
        btns = 2'($urandom_range(3, 1));
      end else begin
        btns = {l0, r0};
      end
      send_item(FuncSample, btns[1], btns[0], press_at + $urandom_range(hold));
    end
    stamp_ms = press_at + hold;
    send_item(FuncSample, 1'b0, 1'b0, stamp_ms);
  endtask

  task automatic send_noise();
    logic [TimeW-1:0] at;
    case ($urandom_range(9))
      0, 1, 2: begin
        at       = $urandom();
        stamp_ms = at;
      end
      3: begin
        at       = 32'hFFFF_FFFF - $urandom_range(4000);
        stamp_ms = at;
      end
      default: at = stamp_ms + $urandom_range(2000);
    endcase
    send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)), at);
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = RegLongPressMs;
    cfg_wdata             = '0;
    item_if.valid         = 1'b0;
    item_if.func          = FuncSample;
    item_if.left_pressed  = 1'b0;
    item_if.right_pressed = 1'b0;
    item_if.now_ms        = '0;
    result_if.ready       = 1'b0;
    quiet_cycles          = 0;
    items_sent            = 0;
    last_side             = 0;
    stamp_ms              = '0;
    long_ms               = LongPressResetMs;
    gap_ms                = DoubleGapResetMs;
    send_idle_pct         = 13;
    recv_idle_pct         = 82;

    // opening at the reset limits: long 800, gap 600
    opening_seq = '{
      '{FuncSample, 1'b1, 1'b0, 32'd1000},        // left press
      '{FuncSample, 1'b0, 1'b0, 32'd1100},        // short release, now pending
      '{FuncTick,   1'b1, 1'b1, 32'd1700},        // tick exactly at the gap
      '{FuncTick,   1'b0, 1'b0, 32'd1701},        // tick past the gap: short left
      '{FuncSample, 1'b0, 1'b1, 32'd2000},
      '{FuncSample, 1'b0, 1'b0, 32'd2800},        // held exactly the limit: long right
      '{FuncSample, 1'b1, 1'b0, 32'd3000},
      '{FuncSample, 1'b0, 1'b0, 32'd3799},        // one below the limit
      '{FuncSample, 1'b1, 1'b0, 32'd4399},        // press at the gap: double left
      '{FuncSample, 1'b1, 1'b1, 32'd4400},
      '{FuncSample, 1'b0, 1'b0, 32'd9000},        // release of the double is silent
      '{FuncSample, 1'b1, 1'b1, 32'd10000},
      '{FuncSample, 1'b0, 1'b0, 32'd10050},       // both pending
      '{FuncSample, 1'b1, 1'b0, 32'd10100},       // other side: short both
      '{FuncSample, 1'b0, 1'b0, 32'd20000},       // long left
      '{FuncSample, 1'b0, 1'b1, 32'd30000},       // right first, then both
      '{FuncSample, 1'b1, 1'b1, 32'd30010},
      '{FuncSample, 1'b0, 1'b0, 32'd30020},
      '{FuncSample, 1'b1, 1'b1, 32'd30030},       // first-sample side differs: short
      '{FuncSample, 1'b0, 1'b0, 32'hFFFF_FF00},
      '{FuncSample, 1'b0, 1'b0, 32'hFFFF_FF10},   // release with nothing held
      '{FuncSample, 1'b1, 1'b0, 32'hFFFF_FFFF},
      '{FuncSample, 1'b0, 1'b0, 32'h0000_0100},   // hold across the wrap
      '{FuncTick,   1'b0, 1'b0, 32'h0000_0358},
      '{FuncSample, 1'b1, 1'b0, 32'h0000_0358}    // double across the wrap
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_seq[i]) begin
      send_item(opening_seq[i].func, opening_seq[i].left_pressed,
                opening_seq[i].right_pressed, opening_seq[i].now_ms);
    end
    stamp_ms = 32'h0000_0400;

    for (int unsigned phase = 0; phase < 6; phase++) begin
      settle();
      case (phase / 2)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: write_limits(16'h0000, 16'h0000);
        1: write_limits(16'hFFFF, 16'hFFFF);
        2: write_limits(LimitW'($urandom_range(3000, 1)), LimitW'($urandom_range(3000, 1)));
        3: write_limits(LimitW'($urandom()), LimitW'($urandom()));
        4: write_limits(LimitW'($urandom_range(3000, 1)), 16'h0000);
        default: write_limits(LongPressResetMs, DoubleGapResetMs);
      endcase
      while (items_sent < 25 + (phase + 1) * PhaseItems) begin
        if ($urandom_range(99) < 15) begin
          send_noise();
        end else begin
          play_gesture();
        end
      end
    end

    settle();
    @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bgc_pkg.sv
rtl/bgc_item_if.sv
rtl/bgc_result_if.sv
rtl/bgc_cfg_regs.sv
rtl/bgc_core.sv
rtl/button_gesture_classifier.sv
test/button_gesture_classifier_checker.sv
test/button_gesture_classifier_test.sv
